### rtl/core/lpcc_pkg.sv
// Package: shared types, constants, arctangent table and angle-difference fold for the pair check.
`timescale 1ns / 1ps
package lpcc_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int AW = 34;
    localparam int ZW = 26;

    localparam logic [2:0] FC_PASS = 3'd0;
    localparam logic [2:0] FC_LENGTH = 3'd1;
    localparam logic [2:0] FC_POS = 3'd2;
    localparam logic [2:0] FC_SPACING = 3'd3;
    localparam logic [2:0] FC_HEADING = 3'd4;
    localparam logic [2:0] FC_AREA = 3'd5;

    localparam logic [2:0] REG_LEN = 3'd0;
    localparam logic [2:0] REG_SMIN = 3'd1;
    localparam logic [2:0] REG_SMAX = 3'd2;
    localparam logic [2:0] REG_HEAD = 3'd3;
    localparam logic [2:0] REG_POS = 3'd4;
    localparam logic [2:0] REG_AREA = 3'd5;

    typedef struct packed {
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0: v = 26'sd2949120;   1: v = 26'sd1740967;  2: v = 26'sd919879;
            3: v = 26'sd466945;    4: v = 26'sd234379;   5: v = 26'sd117304;
            6: v = 26'sd58666;     7: v = 26'sd29335;    8: v = 26'sd14668;
            9: v = 26'sd7334;      10: v = 26'sd3667;    11: v = 26'sd1833;
            12: v = 26'sd917;      13: v = 26'sd458;     14: v = 26'sd229;
            15: v = 26'sd115;      16: v = 26'sd57;      17: v = 26'sd29;
            18: v = 26'sd14;       19: v = 26'sd7;       20: v = 26'sd4;
            21: v = 26'sd2;        22: v = 26'sd1;       default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] fold_diff(input logic signed [18:0] a,
                                              input logic signed [18:0] b);
        logic signed [19:0] d;
        begin
            d = 20'(a) - 20'(b);
            if (d < 0) d = -d;
            if (d > 20'sd23040) d = 20'sd46080 - d;
            return (d < 0) ? 18'd0 : d[17:0];
        end
    endfunction
endpackage

### rtl/core/lpcc_cordic.sv
// Pipelined vectoring CORDIC: one rotation step per register stage.
`timescale 1ns / 1ps
module lpcc_cordic (
    input  logic             i_clk,
    input  lpcc_pkg::t_cordic i_data,
    output lpcc_pkg::t_cordic o_data
);
    import lpcc_pkg::*;

    t_cordic r_st [CORDIC_STEPS+1];

    always_comb r_st[0] = i_data;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        t_cordic n_st;
        logic signed [AW-1:0] xs, ys;
        always_comb begin
            xs = r_st[g].x >>> g;
            ys = r_st[g].y >>> g;
            n_st = r_st[g];
            if (!r_st[g].y[AW-1]) begin
                n_st.x = r_st[g].x + ys;
                n_st.y = r_st[g].y - xs;
                n_st.z = r_st[g].z + atan_tab(g);
            end else begin
                n_st.x = r_st[g].x - ys;
                n_st.y = r_st[g].y + xs;
                n_st.z = r_st[g].z - atan_tab(g);
            end
        end
        always_ff @(posedge i_clk) begin
            r_st[g+1] <= n_st;
        end
    end

    assign o_data = r_st[CORDIC_STEPS];
endmodule

### rtl/core/light_pair_compatibility_check.sv
// Top level: light bar pair compatibility check pipeline.
`timescale 1ns / 1ps
// Takes one bar pair per clock whenever start is high; busy stays low, so
// pairs may stream back to back. Each pair yields exactly one result strobe,
// registered through stage 1, the pipelined CORDIC that measures the
// joining-line angle (one rotation per stage), and stages A to D. The
// receiver cannot stall; results come in input order. Registers must be
// written only while no pair is in flight.
module light_pair_compatibility_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_first_center_x,
    input  logic [15:0]        i_first_center_y,
    input  logic [15:0]        i_first_length,
    input  logic signed [16:0] i_first_tilt,
    input  logic [15:0]        i_second_center_x,
    input  logic [15:0]        i_second_center_y,
    input  logic [15:0]        i_second_length,
    input  logic signed [16:0] i_second_tilt,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output logic               o_strobe,
    output logic               o_pair_match,
    output logic [2:0]         o_fail_code
);
    import lpcc_pkg::*;

    localparam int L = CORDIC_STEPS;

    logic [15:0] r_len_ratio, r_smin, r_smax;
    logic [14:0] r_head, r_pos;
    logic [23:0] r_area;

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_ratio <= 16'd13107; r_smin <= 16'd256; r_smax <= 16'd1280;
            r_head <= 15'd2560; r_pos <= 15'd5120; r_area <= 24'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LEN:  r_len_ratio <= i_cfg_data[15:0];
                REG_SMIN: r_smin <= i_cfg_data[15:0];
                REG_SMAX: r_smax <= i_cfg_data[15:0];
                REG_HEAD: r_head <= i_cfg_data[14:0];
                REG_POS:  r_pos <= i_cfg_data[14:0];
                REG_AREA: r_area <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // stage 1: differences, length sum, special angles, cordic pre-rotation
    logic               r1_v;
    logic signed [16:0] r1_dx, r1_dy;
    logic [16:0]        r1_sum, r1_diff;
    logic signed [16:0] r1_ta, r1_tb;
    logic               r1_spec;
    logic signed [18:0] r1_sang;
    t_cordic            r1_c;

    logic signed [16:0] n_dx, n_dy;
    always_comb begin
        n_dx = 17'(i_first_center_x) - 17'(i_second_center_x);
        n_dy = 17'(i_first_center_y) - 17'(i_second_center_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= start;
        r1_dx <= n_dx; r1_dy <= n_dy;
        r1_sum <= 17'(i_first_length) + 17'(i_second_length);
        r1_diff <= (i_first_length > i_second_length) ?
                   17'(i_first_length - i_second_length) :
                   17'(i_second_length - i_first_length);
        r1_ta <= i_first_tilt; r1_tb <= i_second_tilt;
        r1_spec <= (n_dy == 0) || (n_dx == 0);
        if (n_dy == 0) r1_sang <= (n_dx < 0) ? 19'sd46080 : 19'sd0;
        else r1_sang <= (n_dy > 0) ? 19'sd23040 : -19'sd23040;
        r1_c.x <= (n_dx < 0) ? -(AW'(n_dx) <<< 8) : (AW'(n_dx) <<< 8);
        r1_c.y <= (n_dx < 0) ? -(AW'(n_dy) <<< 8) : (AW'(n_dy) <<< 8);
        r1_c.z <= (n_dx < 0) ? ((n_dy > 0) ? 26'sd11796480 : -26'sd11796480)
                             : '0;
    end

    t_cordic c_out;
    lpcc_cordic u_cordic (.i_clk(i_clk), .i_data(r1_c), .o_data(c_out));

    // side-band delay alongside the cordic, squared distance computed on entry
    typedef struct packed {
        logic               v;
        logic [16:0]        sum;
        logic [16:0]        diff;
        logic signed [16:0] ta;
        logic signed [16:0] tb;
        logic               spec;
        logic signed [18:0] sang;
        logic [32:0]        d2;
    } t_side;

    t_side r_sd [L+1];
    logic signed [32:0] n_sqx, n_sqy;
    logic [32:0] n_d2;
    always_comb begin
        n_sqx = 33'(r1_dx) * 33'(r1_dx);
        n_sqy = 33'(r1_dy) * 33'(r1_dy);
        n_d2 = $unsigned(n_sqx) + $unsigned(n_sqy);
        r_sd[0] = '{v: r1_v, sum: r1_sum, diff: r1_diff, ta: r1_ta, tb: r1_tb,
                    spec: r1_spec, sang: r1_sang, d2: n_d2};
    end
    for (genvar g = 0; g < L; g++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sd[g+1].v <= 1'b0;
            else r_sd[g+1].v <= r_sd[g].v;
            r_sd[g+1].sum <= r_sd[g].sum; r_sd[g+1].diff <= r_sd[g].diff;
            r_sd[g+1].ta <= r_sd[g].ta;   r_sd[g+1].tb <= r_sd[g].tb;
            r_sd[g+1].spec <= r_sd[g].spec; r_sd[g+1].sang <= r_sd[g].sang;
            r_sd[g+1].d2 <= r_sd[g].d2;
        end
    end
    t_side sd;
    assign sd = r_sd[L];

    // stage A: angle fold, length product, sum squared
    logic               ra_v, ra_len_ok;
    logic signed [18:0] ra_ang;
    logic [16:0]        ra_sum;
    logic signed [16:0] ra_ta, ra_tb;
    logic [32:0]        ra_d2;
    logic [33:0]        ra_sum2;
    logic signed [ZW:0] n_zr;
    logic signed [18:0] n_ang;
    always_comb begin
        n_zr = (27'(c_out.z) + 27'sd128) >>> 8;
        n_ang = sd.spec ? sd.sang : 19'(n_zr);
        if (n_ang > 19'sd23040) n_ang = n_ang - 19'sd46080;
        else if (n_ang < -19'sd23040) n_ang = n_ang + 19'sd46080;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ra_v <= 1'b0;
        else ra_v <= sd.v;
        ra_len_ok <= ({sd.diff, 16'd0} < 33'(r_len_ratio) * 33'(sd.sum));
        ra_ang <= n_ang; ra_sum <= sd.sum; ra_ta <= sd.ta; ra_tb <= sd.tb;
        ra_d2 <= sd.d2;
        ra_sum2 <= 34'(sd.sum) * 34'(sd.sum);
    end

    // stage B: angle checks, ratio products
    logic        rb_v, rb_len_ok, rb_pos_ok, rb_head_ok;
    logic [32:0] rb_rmax, rb_rmin, rb_d2;
    logic [33:0] rb_sum2;
    logic [33:0] rb_lim;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rb_v <= 1'b0;
        else rb_v <= ra_v;
        rb_len_ok <= ra_len_ok;
        rb_pos_ok <= (fold_diff(19'(ra_ta), ra_ang) <= 18'(r_pos)) &&
                     (fold_diff(19'(ra_tb), ra_ang) <= 18'(r_pos));
        rb_head_ok <= fold_diff(19'(ra_ta), 19'(ra_tb)) <= 18'(r_head);
        rb_rmax <= 33'(r_smax) * 33'(ra_sum);
        rb_rmin <= 33'(r_smin) * 33'(ra_sum);
        rb_lim <= {1'b0, r_area, 9'd0};
        rb_d2 <= ra_d2; rb_sum2 <= ra_sum2;
    end

    // stage C: squares and area product
    logic        rc_v, rc_len_ok, rc_pos_ok, rc_head_ok;
    logic [65:0] rc_max2, rc_min2, rc_lim2, rc_d2s;
    logic [66:0] rc_ar;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rc_v <= 1'b0;
        else rc_v <= rb_v;
        rc_len_ok <= rb_len_ok; rc_pos_ok <= rb_pos_ok; rc_head_ok <= rb_head_ok;
        rc_max2 <= 66'(rb_rmax) * 66'(rb_rmax);
        rc_min2 <= 66'(rb_rmin) * 66'(rb_rmin);
        rc_lim2 <= 66'(rb_lim) * 66'(rb_lim);
        rc_d2s <= {15'd0, rb_d2, 18'd0};
        rc_ar <= 67'(rb_sum2) * 67'(rb_d2);
    end

    // stage D: compare and priority
    logic       r_strobe;
    logic [2:0] r_code;
    logic [2:0] n_code;
    always_comb begin
        if (!rc_len_ok) n_code = FC_LENGTH;
        else if (!rc_pos_ok) n_code = FC_POS;
        else if (!((rc_max2 >= rc_d2s) && (rc_d2s >= rc_min2))) n_code = FC_SPACING;
        else if (!rc_head_ok) n_code = FC_HEADING;
        else if (!(rc_ar >= 67'(rc_lim2))) n_code = FC_AREA;
        else n_code = FC_PASS;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else r_strobe <= rc_v;
        r_code <= n_code;
    end

    assign o_strobe = r_strobe;
    assign o_fail_code = r_code;
    assign o_pair_match = (r_code == FC_PASS);

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rc_v |=> o_strobe) else $error("result strobe lost");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_fail_code <= FC_AREA)) else $error("bad code");
    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_pair_match |-> o_fail_code == FC_PASS)
        else $error("match mismatch");
`endif
endmodule

### sim/tb_light_pair_compatibility_check.sv
// Testbench: light bar pair compatibility check against a behavioral predictor.
`timescale 1ns / 1ps
module tb_light_pair_compatibility_check;
    import lpcc_pkg::*;

    localparam int LATENCY = CORDIC_STEPS + 5;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [15:0]        i_first_center_x = '0;
    logic [15:0]        i_first_center_y = '0;
    logic [15:0]        i_first_length = '0;
    logic signed [16:0] i_first_tilt = '0;
    logic [15:0]        i_second_center_x = '0;
    logic [15:0]        i_second_center_y = '0;
    logic [15:0]        i_second_length = '0;
    logic signed [16:0] i_second_tilt = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;
    logic               o_strobe;
    logic               o_pair_match;
    logic [2:0]         o_fail_code;

    typedef struct packed {
        logic [15:0]        ax;
        logic [15:0]        ay;
        logic [15:0]        ha;
        logic signed [16:0] ta;
        logic [15:0]        bx;
        logic [15:0]        by;
        logic [15:0]        hb;
        logic signed [16:0] tb;
    } t_pair;

    typedef struct packed {
        logic       match;
        logic [2:0] code;
    } t_verdict;

    logic [15:0] len_ratio_lim;
    logic [15:0] spacing_min;
    logic [15:0] spacing_max;
    logic [14:0] heading_lim;
    logic [14:0] position_lim;
    logic [23:0] area_min;

    t_verdict verdict_q[$];
    int       n_errors = 0;
    int       n_pairs = 0;
    int       n_verdicts = 0;
    int       code_hits[6];
    bit       quiet = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    light_pair_compatibility_check u_dut (.*);

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint join_angle(longint dx, longint dy);
        longint x, y, z, xs, ys;
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                            29, 14, 7, 4, 2, 1, 0};
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (dy == 0) return (dx < 0) ? 46080 : 0;
        if (dx == 0) return (dy > 0) ? 23040 : -23040;
        x = dx * 256;
        y = dy * 256;
        if (x < 0) begin
            z = (y > 0) ? 46080 * 256 : -46080 * 256;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = fl_shift(x, i);
            ys = fl_shift(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += tab[i];
            end else begin
                x -= ys; y += xs; z -= tab[i];
            end
        end
        return fl_shift(z + 128, 8);
    endfunction

    function automatic longint angle_gap(longint a, longint b);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        if (d > 23040) d = 46080 - d;
        return d;
    endfunction

    function automatic t_verdict judge_pair(t_pair p);
        longint dx, dy, ang;
        logic [127:0] sum, diff, d2, rmax, rmin, lim;
        t_verdict v;
        v.code = FC_PASS;
        dx = longint'(p.ax) - longint'(p.bx);
        dy = longint'(p.ay) - longint'(p.by);
        sum = 128'(p.ha) + 128'(p.hb);
        diff = (p.ha > p.hb) ? 128'(p.ha - p.hb) : 128'(p.hb - p.ha);
        d2 = 128'(dx * dx + dy * dy);
        if (!(diff * 65536 < 128'(len_ratio_lim) * sum)) begin
            v.code = FC_LENGTH;
        end else begin
            ang = join_angle(dx, dy);
            if (ang > 23040) ang -= 46080;
            else if (ang < -23040) ang += 46080;
            rmax = 128'(spacing_max) * sum;
            rmin = 128'(spacing_min) * sum;
            lim = 128'(area_min) * 512;
            if (angle_gap(p.ta, ang) > longint'(position_lim) ||
                angle_gap(p.tb, ang) > longint'(position_lim))
                v.code = FC_POS;
            else if (!(rmax * rmax >= 262144 * d2 && 262144 * d2 >= rmin * rmin))
                v.code = FC_SPACING;
            else if (angle_gap(p.ta, p.tb) > longint'(heading_lim))
                v.code = FC_HEADING;
            else if (!(sum * sum * d2 >= lim * lim))
                v.code = FC_AREA;
        end
        v.match = (v.code == FC_PASS);
        return v;
    endfunction

    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic send_pair(t_pair p);
        idle_burst();
        start <= 1'b1;
        i_first_center_x <= p.ax;
        i_first_center_y <= p.ay;
        i_first_length <= p.ha;
        i_first_tilt <= p.ta;
        i_second_center_x <= p.bx;
        i_second_center_y <= p.by;
        i_second_length <= p.hb;
        i_second_tilt <= p.tb;
        do @(posedge i_clk); while (busy);
        verdict_q = {verdict_q, judge_pair(p)};
        n_pairs++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_LEN:  len_ratio_lim = val[15:0];
            REG_SMIN: spacing_min = val[15:0];
            REG_SMAX: spacing_max = val[15:0];
            REG_HEAD: heading_lim = val[14:0];
            REG_POS:  position_lim = val[14:0];
            REG_AREA: area_min = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(int lr, int smin, int smax, int hd, int pd, int ar);
        write_reg(REG_LEN, 24'(lr));
        write_reg(REG_SMIN, 24'(smin));
        write_reg(REG_SMAX, 24'(smax));
        write_reg(REG_HEAD, 24'(hd));
        write_reg(REG_POS, 24'(pd));
        write_reg(REG_AREA, 24'(ar));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_pair make_pair(int ax, int ay, int ha, int ta,
                                        int bx, int by, int hb, int tb);
        t_pair p;
        p = '{16'(ax), 16'(ay), 16'(ha), 17'(ta), 16'(bx), 16'(by), 16'(hb), 17'(tb)};
        return p;
    endfunction

    // Plausible pair: similar lengths, spacing near a few lengths, small tilts.
    function automatic t_pair realistic_pair();
        t_pair p;
        int h, gap_px, ang;
        h = $urandom_range(16, 2000);
        gap_px = h * $urandom_range(1, 6) + $urandom_range(0, h);
        ang = $urandom_range(0, 1) ? $urandom_range(0, 6000) : -$urandom_range(0, 6000);
        p.ax = 16'($urandom_range(0, 65535 - gap_px));
        p.ay = 16'($urandom_range(1000, 64000));
        p.bx = p.ax + 16'(gap_px);
        p.by = p.ay + 16'($urandom_range(0, gap_px / 4)) - 16'(gap_px / 8);
        p.ha = 16'(h);
        p.hb = 16'(h + $urandom_range(0, h / 2) - h / 4);
        p.ta = 17'(ang);
        p.tb = 17'(ang + $urandom_range(0, 3000) - 1500);
        if ($urandom_range(0, 1)) p.ta = -p.ta;
        if ($urandom_range(0, 1)) p.tb = -p.tb;
        return p;
    endfunction

    function automatic t_pair noise_pair();
        t_pair p;
        p = {$urandom(), $urandom(), $urandom(), $urandom()};
        p.ta = 17'($urandom_range(0, 92160)) - 17'sd46080;
        p.tb = 17'($urandom_range(0, 92160)) - 17'sd46080;
        if ($urandom_range(0, 7) == 0) p.ta = 17'($urandom());
        if ($urandom_range(0, 7) == 0) p.tb = 17'($urandom());
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_strobe) begin
            if (verdict_q.size() == 0) begin
                $error("result with nothing expected: match %0d code %0d",
                       o_pair_match, o_fail_code);
                n_errors++;
            end else begin
                exp_v = verdict_q.pop_front();
                n_verdicts++;
                code_hits[exp_v.code]++;
                if (o_pair_match !== exp_v.match) begin
                    $error("pair_match expected %0d actual %0d", exp_v.match, o_pair_match);
                    n_errors++;
                end
                if (o_fail_code !== exp_v.code) begin
                    $error("fail_code expected %0d actual %0d", exp_v.code, o_fail_code);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_pair(make_pair(1000, 1000, 160, 0, 2000, 1000, 160, 0));
        send_pair(make_pair(1000, 1000, 160, 0, 2000, 1000, 60, 0));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(500, 500, 160, 0, 500, 500, 160, 0));
        send_pair(make_pair(2000, 1000, 160, 46080, 1000, 1000, 160, -46080));
        send_pair(make_pair(1000, 2000, 160, 23040, 1000, 1000, 160, -23040));
        send_pair(make_pair(1000, 1000, 160, 23040, 1000, 2000, 160, 23040));
        send_pair(make_pair(1000, 1000, 160, 5000, 2000, 1300, 160, 5000));
        send_pair(make_pair(2000, 1300, 160, 0, 1000, 1000, 160, 0));
        send_pair(make_pair(2000, 700, 160, 0, 1000, 1000, 160, 0));
        send_pair(make_pair(1000, 1000, 160, 0, 1100, 1000, 160, 0));
        send_pair(make_pair(0, 1000, 160, 0, 65535, 1000, 160, 0));
        send_pair(make_pair(1000, 1000, 160, 4000, 1400, 1000, 160, -1000));
        send_pair(make_pair(0, 0, 65535, 65535, 65535, 65535, 65535, -65536));
        send_pair(make_pair(65535, 65535, 1, -46080, 0, 0, 1, 46080));
        send_pair(make_pair(1000, 1000, 2, 30000, 1005, 1001, 2, -30000));
        send_pair(make_pair(1000, 1000, 4, 0, 1010, 1000, 4, 0));
        send_pair(make_pair(1000, 1000, 1600, 0, 9000, 1000, 1600, 0));
    endtask

    task automatic test_register_extremes();
        drain();
        load_regs(65535, 0, 65535, 23040, 23040, 0);
        for (int i = 0; i < 20; i++) send_pair(noise_pair());
        drain();
        load_regs(0, 65535, 0, 0, 0, 16777215);
        for (int i = 0; i < 10; i++) send_pair(realistic_pair());
        drain();
        load_regs(32767, 128, 4000, 32767, 32767, 5000);
        for (int i = 0; i < 20; i++) send_pair(noise_pair());
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) send_pair(noise_pair());
            else send_pair(realistic_pair());
            if (i == n / 2) drain();
        end
    endtask

    task automatic test_streaming(int n);
        quiet = 1'b1;
        for (int i = 0; i < n; i++) send_pair(realistic_pair());
        quiet = 1'b0;
    endtask

    initial begin
        len_ratio_lim = 16'd13107;
        spacing_min = 16'd256;
        spacing_max = 16'd1280;
        heading_lim = 15'd2560;
        position_lim = 15'd5120;
        area_min = 24'd100;
        foreach (code_hits[i]) code_hits[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        load_regs(20000, 200, 1800, 4000, 6000, 50);
        test_random(500);
        drain();
        load_regs(13107, 256, 1280, 2560, 5120, 100);
        test_random(300);
        test_streaming(180);
        drain();
        $display("%0d pairs sent, %0d results checked over several register settings",
                 n_pairs, n_verdicts);
        $display("codes seen: pass %0d len %0d pos %0d spc %0d head %0d area %0d",
                 code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4],
                 code_hits[5]);
        if (n_errors == 0 && verdict_q.size() == 0)
            $display("** light_pair_compatibility_check: PASSED **");
        else
            $display("** light_pair_compatibility_check: FAILED **");
        $finish;
    end

    initial begin
        #2ms;
        $display("** light_pair_compatibility_check: FAILED **");
        $finish;
    end
endmodule
